### sv/spmqm_pkg.sv
package spmqm_pkg;

    localparam int DEF_POOL_NODES   = 64;
    localparam int DEF_QUEUE_COUNT  = 64;
    localparam int DEF_MEMBER_WIDTH = 16;

    localparam logic [2:0] OP_ENQUEUE = 3'd0;
    localparam logic [2:0] OP_DEQUEUE = 3'd1;
    localparam logic [2:0] OP_FLUSH   = 3'd2;
    localparam logic [2:0] OP_QUERY   = 3'd3;
    localparam logic [2:0] OP_PURGE   = 3'd4;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    localparam logic [4:0] ST_NONE         = 5'd0;
    localparam logic [4:0] ST_LOAD         = 5'd1;
    localparam logic [4:0] ST_CLEAR        = 5'd2;
    localparam logic [4:0] ST_ENQ_FULL     = 5'd3;
    localparam logic [4:0] ST_ENQ_TAKE     = 5'd4;
    localparam logic [4:0] ST_ENQ_LINK     = 5'd5;
    localparam logic [4:0] ST_DEQ_EMPTY    = 5'd6;
    localparam logic [4:0] ST_DEQ_READ     = 5'd7;
    localparam logic [4:0] ST_DEQ_POP      = 5'd8;
    localparam logic [4:0] ST_HEAD         = 5'd9;
    localparam logic [4:0] ST_NODE_READ    = 5'd10;
    localparam logic [4:0] ST_FLUSH_END    = 5'd11;
    localparam logic [4:0] ST_QUERY_END    = 5'd12;
    localparam logic [4:0] ST_PURGE_QEND   = 5'd13;
    localparam logic [4:0] ST_FLUSH_NODE   = 5'd14;
    localparam logic [4:0] ST_QUERY_NODE   = 5'd15;
    localparam logic [4:0] ST_PURGE_KEEP   = 5'd16;
    localparam logic [4:0] ST_PURGE_DROP   = 5'd17;
    localparam logic [4:0] ST_PURGE_RELINK = 5'd18;
    localparam logic [4:0] ST_OTHER        = 5'd19;

    typedef struct packed {
        logic [4:0] step;
        logic       emit;
    } t_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       free_nil;
        logic       head_nil;
        logic       node_nil;
        logic       prev_ok;
        logic       match;
        logic       last_q;
        logic       clr_last;
    } t_stat;

    function automatic logic [6:0] sat7(input logic [31:0] v);
        return (v > 32'd127) ? 7'd127 : v[6:0];
    endfunction

endpackage

### sv/shared_pool_multi_queue_manager.sv
// Pool-shared multi-queue manager: QUEUE_COUNT linked FIFO queues of member ids drawing
// nodes from one POOL_NODES-node free list. Raise i_start with the operation while
// o_busy is low; exactly one result word follows on the o_ ports, marked by a one-cycle
// o_valid pulse, and must be taken in that cycle since the block cannot hold it. After
// reset o_busy stays high while the link memory is chained into the free list and the
// queue memory is cleared. Every step is a registered memory access: enqueue reads the
// queue word, takes the free head node and links it at the tail (or reports full when
// the pool is exhausted), dequeue reads the head node and pops it (or reports empty),
// flush and query walk the queue's nodes, and purge walks every queue, unlinking each
// entry whose member id matches and relinking its predecessor when it has one.
module shared_pool_multi_queue_manager import spmqm_pkg::*; #(
    parameter int POOL_NODES   = DEF_POOL_NODES,
    parameter int QUEUE_COUNT  = DEF_QUEUE_COUNT,
    parameter int MEMBER_WIDTH = DEF_MEMBER_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [2:0]  i_operation,
    input  logic [5:0]  i_queue_id,
    input  logic [15:0] i_member_id,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [15:0] o_member_out,
    output logic        o_found,
    output logic [6:0]  o_queue_length,
    output logic [6:0]  o_freed_count
);

    t_cmd  cmd;
    t_stat stat;

    spmqm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .i_operation (i_operation),
        .i_stat      (stat),
        .o_cmd       (cmd),
        .o_busy      (o_busy)
    );

    spmqm_datapath #(
        .POOL_NODES   (POOL_NODES),
        .QUEUE_COUNT  (QUEUE_COUNT),
        .MEMBER_WIDTH (MEMBER_WIDTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (cmd),
        .i_operation    (i_operation),
        .i_queue_id     (i_queue_id),
        .i_member_id    (i_member_id),
        .o_stat         (stat),
        .o_valid        (o_valid),
        .o_status       (o_status),
        .o_member_out   (o_member_out),
        .o_found        (o_found),
        .o_queue_length (o_queue_length),
        .o_freed_count  (o_freed_count)
    );

endmodule

### sv/spmqm_ctrl.sv
module spmqm_ctrl import spmqm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_start,
    input  logic [2:0] i_operation,
    input  t_stat      i_stat,
    output t_cmd       o_cmd,
    output logic       o_busy
);

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_EA   = 4'd2;
    localparam logic [3:0] S_EB   = 4'd3;
    localparam logic [3:0] S_DA   = 4'd4;
    localparam logic [3:0] S_DB   = 4'd5;
    localparam logic [3:0] S_WH   = 4'd6;
    localparam logic [3:0] S_WC   = 4'd7;
    localparam logic [3:0] S_WD   = 4'd8;
    localparam logic [3:0] S_PL   = 4'd9;
    localparam logic [3:0] S_OTH  = 4'd10;

    logic [3:0] r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

    always_comb begin
        n_state    = r_state;
        o_cmd.step = ST_NONE;
        o_cmd.emit = 1'b0;
        unique case (r_state)
            S_CLR: begin
                o_cmd.step = ST_CLEAR;
                if (i_stat.clr_last) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.step = ST_LOAD;
                    unique case (i_operation) inside
                        OP_ENQUEUE: n_state = S_EA;
                        OP_DEQUEUE: n_state = S_DA;
                        OP_FLUSH, OP_QUERY, OP_PURGE: n_state = S_WH;
                        default: n_state = S_OTH;
                    endcase
                end
            end
            S_EA: begin
                if (i_stat.free_nil) begin
                    o_cmd.step = ST_ENQ_FULL;
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    o_cmd.step = ST_ENQ_TAKE;
                    n_state    = S_EB;
                end
            end
            S_EB: begin
                o_cmd.step = ST_ENQ_LINK;
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            S_DA: begin
                if (i_stat.head_nil) begin
                    o_cmd.step = ST_DEQ_EMPTY;
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end else begin
                    o_cmd.step = ST_DEQ_READ;
                    n_state    = S_DB;
                end
            end
            S_DB: begin
                o_cmd.step = ST_DEQ_POP;
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            S_WH: begin
                o_cmd.step = ST_HEAD;
                n_state    = S_WC;
            end
            S_WC: begin
                if (i_stat.node_nil) begin
                    if (i_stat.op == OP_FLUSH) begin
                        o_cmd.step = ST_FLUSH_END;
                        o_cmd.emit = 1'b1;
                        n_state    = S_IDLE;
                    end else if (i_stat.op == OP_QUERY) begin
                        o_cmd.step = ST_QUERY_END;
                        o_cmd.emit = 1'b1;
                        n_state    = S_IDLE;
                    end else begin
                        o_cmd.step = ST_PURGE_QEND;
                        o_cmd.emit = i_stat.last_q;
                        n_state    = i_stat.last_q ? S_IDLE : S_WH;
                    end
                end else begin
                    o_cmd.step = ST_NODE_READ;
                    n_state    = S_WD;
                end
            end
            S_WD: begin
                n_state = S_WC;
                if (i_stat.op == OP_FLUSH) begin
                    o_cmd.step = ST_FLUSH_NODE;
                end else if (i_stat.op == OP_QUERY) begin
                    o_cmd.step = ST_QUERY_NODE;
                end else if (i_stat.match) begin
                    o_cmd.step = ST_PURGE_DROP;
                    if (i_stat.prev_ok) n_state = S_PL;
                end else begin
                    o_cmd.step = ST_PURGE_KEEP;
                end
            end
            S_PL: begin
                o_cmd.step = ST_PURGE_RELINK;
                n_state    = S_WC;
            end
            S_OTH: begin
                o_cmd.step = ST_OTHER;
                o_cmd.emit = 1'b1;
                n_state    = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

### sv/spmqm_datapath.sv
module spmqm_datapath import spmqm_pkg::*; #(
    parameter int POOL_NODES   = DEF_POOL_NODES,
    parameter int QUEUE_COUNT  = DEF_QUEUE_COUNT,
    parameter int MEMBER_WIDTH = DEF_MEMBER_WIDTH
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [2:0]  i_operation,
    input  logic [5:0]  i_queue_id,
    input  logic [15:0] i_member_id,
    output t_stat       o_stat,
    output logic        o_valid,
    output logic [1:0]  o_status,
    output logic [15:0] o_member_out,
    output logic        o_found,
    output logic [6:0]  o_queue_length,
    output logic [6:0]  o_freed_count
);

    localparam int NW   = $clog2(POOL_NODES + 1);
    localparam int NIW  = $clog2(POOL_NODES);
    localparam int QW   = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
    localparam int MW   = MEMBER_WIDTH;
    localparam int MAXD = (POOL_NODES > QUEUE_COUNT) ? POOL_NODES : QUEUE_COUNT;
    localparam int CLW  = $clog2(MAXD);
    localparam logic [NW-1:0] NIL = NW'(POOL_NODES);

    typedef struct packed {
        logic [NW-1:0] head;
        logic [NW-1:0] tail;
        logic [NW-1:0] count;
    } t_qword;

    localparam t_qword QEMPTY = '{head: NIL, tail: NIL, count: '0};

    function automatic logic [64*QW-1:0] qmap_build();
        int                c;
        logic [64*QW-1:0]  t;
        c = 0;
        t = '0;
        for (int i = 0; i < 64; i++) begin
            t[i*QW +: QW] = QW'(c);
            c = c + 1;
            if (c == QUEUE_COUNT) c = 0;
        end
        return t;
    endfunction

    localparam logic [64*QW-1:0] QMAP = qmap_build();

    logic [NW-1:0] r_link   [POOL_NODES];
    logic [MW-1:0] r_member [POOL_NODES];
    t_qword        r_qmem   [QUEUE_COUNT];

    logic [NW-1:0] r_link_rd;
    logic [MW-1:0] r_member_rd;
    t_qword        r_qmem_rd;

    logic           link_we, member_we, qmem_we;
    logic [NIW-1:0] link_wa, link_ra, member_wa;
    logic [NW-1:0]  link_wd;
    logic [QW-1:0]  qmem_wa, qmem_ra;
    t_qword         qmem_wd;

    logic [2:0]     r_op, n_op;
    logic [QW-1:0]  r_q, n_q;
    logic [MW-1:0]  r_id, n_id;
    logic [NW-1:0]  r_node, n_node;
    logic [NW-1:0]  r_prev, n_prev;
    logic [NW-1:0]  r_free, n_free;
    logic [NW-1:0]  r_freed, n_freed;
    logic           r_fnd, n_fnd;
    logic [CLW-1:0] r_clr, n_clr;
    t_qword         r_qw, n_qw;

    logic        r_valid, n_valid;
    logic [1:0]  r_status, n_status;
    logic [15:0] r_mout, n_mout;
    logic        r_found, n_found;
    logic [6:0]  r_qlen, n_qlen;
    logic [6:0]  r_fcnt, n_fcnt;

    logic [QW-1:0] q_in;

    always_ff @(posedge i_clk) begin
        if (link_we) r_link[link_wa] <= link_wd;
        r_link_rd <= r_link[link_ra];
        if (member_we) r_member[member_wa] <= r_id;
        r_member_rd <= r_member[link_ra];
        if (qmem_we) r_qmem[qmem_wa] <= qmem_wd;
        r_qmem_rd <= r_qmem[qmem_ra];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_free  <= '0;
            r_clr   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_free  <= n_free;
            r_clr   <= n_clr;
            r_valid <= n_valid;
        end
        r_op     <= n_op;
        r_q      <= n_q;
        r_id     <= n_id;
        r_node   <= n_node;
        r_prev   <= n_prev;
        r_freed  <= n_freed;
        r_fnd    <= n_fnd;
        r_qw     <= n_qw;
        r_status <= n_status;
        r_mout   <= n_mout;
        r_found  <= n_found;
        r_qlen   <= n_qlen;
        r_fcnt   <= n_fcnt;
    end

    assign q_in = QMAP[i_queue_id*QW +: QW];

    always_comb begin
        n_op      = r_op;
        n_q       = r_q;
        n_id      = r_id;
        n_node    = r_node;
        n_prev    = r_prev;
        n_free    = r_free;
        n_freed   = r_freed;
        n_fnd     = r_fnd;
        n_clr     = r_clr;
        n_qw      = r_qw;
        n_valid   = i_cmd.emit;
        n_status  = r_status;
        n_mout    = r_mout;
        n_found   = r_found;
        n_qlen    = r_qlen;
        n_fcnt    = r_fcnt;
        link_we   = 1'b0;
        link_wa   = r_node[NIW-1:0];
        link_wd   = r_free;
        link_ra   = r_node[NIW-1:0];
        member_we = 1'b0;
        member_wa = r_free[NIW-1:0];
        qmem_we   = 1'b0;
        qmem_wa   = r_q;
        qmem_wd   = r_qw;
        qmem_ra   = r_q;

        if (i_cmd.emit) begin
            n_status = STAT_OK;
            n_mout   = '0;
            n_found  = 1'b0;
            n_qlen   = '0;
            n_fcnt   = '0;
        end

        case (i_cmd.step)
            ST_LOAD: begin
                n_op    = i_operation;
                n_id    = MW'(i_member_id);
                n_q     = (i_operation == OP_PURGE) ? '0 : q_in;
                qmem_ra = n_q;
                n_freed = '0;
                n_fnd   = 1'b0;
            end
            ST_CLEAR: begin
                if (32'(r_clr) < POOL_NODES) begin
                    link_we = 1'b1;
                    link_wa = r_clr[NIW-1:0];
                    link_wd = NW'(r_clr) + NW'(1);
                end
                if (32'(r_clr) < QUEUE_COUNT) begin
                    qmem_we = 1'b1;
                    qmem_wa = r_clr[QW-1:0];
                    qmem_wd = QEMPTY;
                end
                n_clr = r_clr + CLW'(1);
            end
            ST_ENQ_FULL: begin
                n_status = STAT_FULL;
                n_qlen   = sat7(32'(r_qmem_rd.count));
            end
            ST_ENQ_TAKE: begin
                n_node    = r_free;
                link_ra   = r_free[NIW-1:0];
                member_we = 1'b1;
                n_qw      = r_qmem_rd;
                if (r_qmem_rd.head != NIL && r_qmem_rd.tail != NIL) begin
                    link_we = 1'b1;
                    link_wa = r_qmem_rd.tail[NIW-1:0];
                    link_wd = r_free;
                end
            end
            ST_ENQ_LINK: begin
                n_free  = r_link_rd;
                link_we = 1'b1;
                link_wd = NIL;
                if (!(r_qw.head != NIL && r_qw.tail != NIL)) n_qw.head = r_node;
                n_qw.tail  = r_node;
                n_qw.count = r_qw.count + NW'(1);
                qmem_we    = 1'b1;
                qmem_wd    = n_qw;
                n_qlen     = sat7(32'(n_qw.count));
            end
            ST_DEQ_EMPTY: begin
                n_status = STAT_EMPTY;
                n_qlen   = sat7(32'(r_qmem_rd.count));
            end
            ST_DEQ_READ: begin
                n_node  = r_qmem_rd.head;
                link_ra = r_qmem_rd.head[NIW-1:0];
                n_qw    = r_qmem_rd;
            end
            ST_DEQ_POP: begin
                link_we   = 1'b1;
                n_free    = r_node;
                n_qw.head = r_link_rd;
                if (r_link_rd == NIL) begin
                    n_qw.head = NIL;
                    n_qw.tail = NIL;
                end
                if (r_qw.count != '0) n_qw.count = r_qw.count - NW'(1);
                qmem_we = 1'b1;
                qmem_wd = n_qw;
                n_mout  = 16'(r_member_rd);
                n_qlen  = sat7(32'(n_qw.count));
            end
            ST_HEAD: begin
                n_qw   = r_qmem_rd;
                n_node = r_qmem_rd.head;
                n_prev = NIL;
            end
            ST_FLUSH_END: begin
                qmem_we = 1'b1;
                qmem_wd = QEMPTY;
                n_fcnt  = sat7(32'(r_freed));
            end
            ST_QUERY_END: begin
                n_found = r_fnd;
                n_qlen  = sat7(32'(r_qw.count));
            end
            ST_PURGE_QEND: begin
                qmem_we = 1'b1;
                qmem_wd = (r_qw.head == NIL) ? QEMPTY : r_qw;
                n_q     = QW'(r_q + 1'b1);
                qmem_ra = n_q;
                n_fcnt  = sat7(32'(r_freed));
            end
            ST_FLUSH_NODE: begin
                link_we = 1'b1;
                n_free  = r_node;
                n_freed = r_freed + NW'(1);
                n_node  = r_link_rd;
            end
            ST_QUERY_NODE: begin
                if (r_member_rd == r_id) n_fnd = 1'b1;
                n_node = r_link_rd;
            end
            ST_PURGE_KEEP: begin
                n_prev = r_node;
                n_node = r_link_rd;
            end
            ST_PURGE_DROP: begin
                link_we = 1'b1;
                n_free  = r_node;
                n_freed = r_freed + NW'(1);
                if (r_prev == NIL) n_qw.head = r_link_rd;
                if (r_qw.tail == r_node) n_qw.tail = r_prev;
                if (r_qw.count != '0) n_qw.count = r_qw.count - NW'(1);
                n_node = r_link_rd;
            end
            ST_PURGE_RELINK: begin
                link_we = 1'b1;
                link_wa = r_prev[NIW-1:0];
                link_wd = r_node;
            end
            ST_OTHER: begin
                n_qlen = sat7(32'(r_qmem_rd.count));
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        o_stat.op       = r_op;
        o_stat.free_nil = (r_free == NIL);
        o_stat.head_nil = (r_qmem_rd.head == NIL);
        o_stat.node_nil = (r_node == NIL);
        o_stat.prev_ok  = (r_prev != NIL);
        o_stat.match    = (r_member_rd == r_id);
        o_stat.last_q   = (r_q == QW'(QUEUE_COUNT - 1));
        o_stat.clr_last = (r_clr == CLW'(MAXD - 1));
    end

    assign o_valid        = r_valid;
    assign o_status       = r_status;
    assign o_member_out   = r_mout;
    assign o_found        = r_found;
    assign o_queue_length = r_qlen;
    assign o_freed_count  = r_fcnt;

    a_valid_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |=> !r_valid)
        else $error("result strobe held two cycles");
    a_free_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_free <= NIL)
        else $error("free head out of range");
    a_full_nil: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step == ST_ENQ_FULL) |-> (r_free == NIL))
        else $error("pool full reported with free nodes");
    a_pop_cnt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.step == ST_DEQ_POP) |-> (r_qw.count != '0))
        else $error("pop from queue with zero count");

endmodule
